// ===== design/chm_pkg.sv =====
// Shared constants and types for the chained hash map core.
// No dependencies; imported by chm_hash and chained_hash_map_core.
`timescale 1ns / 1ps

package chm_pkg;

  localparam int BUCKETS    = 63;
  localparam int ENTRIES    = 256;
  localparam int VALUE_BITS = 64;

  localparam int KEY_W  = 31;
  localparam int BKT_W  = $clog2(BUCKETS);
  localparam int IDX_W  = $clog2(ENTRIES);
  localparam int LINK_W = $clog2(ENTRIES + 1);

  // A link or head equal to the entry count marks an empty chain.
  localparam logic [LINK_W-1:0] NIL = LINK_W'(ENTRIES);

  localparam logic [1:0] ACT_SET    = 2'd0;
  localparam logic [1:0] ACT_GET    = 2'd1;
  localparam logic [1:0] ACT_REMOVE = 2'd2;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_HASH  = 7'b0000010,
    S_HEAD  = 7'b0000100,
    S_CMP   = 7'b0001000,
    S_ALLOC = 7'b0010000,
    S_REM1  = 7'b0100000,
    S_REM2  = 7'b1000000
  } state_t;

endpackage

// ===== design/chm_hash.sv =====
// Key magnitude and bucket selection for the chained hash map.
// Depends on chm_pkg.
`timescale 1ns / 1ps

module chm_hash import chm_pkg::*; (
  input  logic signed [31:0]  key,
  output logic [KEY_W-1:0]    magnitude,
  input  logic [KEY_W-1:0]    hash_key,
  output logic [BKT_W-1:0]    bucket
);

  logic [31:0] negated;
  logic [8:0]  digit_sum;
  logic [6:0]  folded;

  always_comb begin
    negated = 32'd0 - key;
    if (!key[31]) begin
      magnitude = key[KEY_W-1:0];
    end else if (negated[31]) begin
      // The most negative key saturates to the largest magnitude.
      magnitude = {KEY_W{1'b1}};
    end else begin
      magnitude = negated[KEY_W-1:0];
    end
  end

  // Since 64 leaves remainder one modulo 63, the six-bit digits are summed
  // and the sum folded once more, leaving a single correction.
  always_comb begin
    digit_sum = 9'(hash_key[5:0]) + 9'(hash_key[11:6]) + 9'(hash_key[17:12])
              + 9'(hash_key[23:18]) + 9'(hash_key[29:24]) + 9'(hash_key[30]);
    folded = 7'(digit_sum[5:0]) + 7'(digit_sum[8:6]);
    if (folded >= 7'(BUCKETS)) begin
      bucket = BKT_W'(folded - 7'(BUCKETS));
    end else begin
      bucket = BKT_W'(folded);
    end
  end

endmodule

// ===== design/chained_hash_map_core.sv =====
// Top level of the chained hash map: sequencer, entry memories and result.
// Depends on chm_pkg and chm_hash.
`timescale 1ns / 1ps

// A transaction is taken when start is high and busy is low. Busy then stays
// high through the hash and head states, a compare step per chain entry
// compared, the allocate state for a new key and the remove states REM1 and
// REM2 for a remove: the single compare unit walks the bucket chain one entry
// per cycle through the registered memory read port. The result is on the
// ports for exactly one cycle with done high, in the cycle after the last busy
// cycle, and cannot be held off by the receiver. A new transaction may be
// taken in that same cycle. No clearing pass is needed after reset: head and
// link valid bits restore the empty map.

module chained_hash_map_core import chm_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  logic [1:0]             action,
  input  logic signed [31:0]     key,
  input  logic [63:0]            value_in,
  output logic                   done,
  output logic                   found,
  output logic [63:0]            value_out,
  output logic                   status,
  output logic [8:0]             entry_count
);

  state_t state;

  logic [1:0]            act;
  logic [KEY_W-1:0]      kmag;
  logic [VALUE_BITS-1:0] val;
  logic [BKT_W-1:0]      bucket;
  logic [LINK_W-1:0]     chain_head;
  logic [IDX_W-1:0]      cur;
  logic [LINK_W-1:0]     prev;
  logic [LINK_W-1:0]     steps;
  logic [LINK_W-1:0]     hit_link;
  logic [LINK_W-1:0]     free_head;
  logic [LINK_W-1:0]     count;

  logic [KEY_W-1:0]      mag_c;
  logic [BKT_W-1:0]      bkt_c;

  logic [LINK_W-1:0]     heads [BUCKETS];
  logic [BUCKETS-1:0]    head_vld;
  logic [KEY_W-1:0]      keys  [ENTRIES];
  logic [VALUE_BITS-1:0] vals  [ENTRIES];
  logic [LINK_W-1:0]     links [ENTRIES];
  logic [ENTRIES-1:0]    link_vld;

  logic [LINK_W-1:0]     head_raw;
  logic                  head_v;
  logic [KEY_W-1:0]      key_q;
  logic [VALUE_BITS-1:0] val_q;
  logic [LINK_W-1:0]     link_raw;
  logic                  link_v;
  logic [IDX_W-1:0]      link_a;

  logic [LINK_W-1:0]     head_q;
  logic [LINK_W-1:0]     link_eff;
  logic [LINK_W-1:0]     steps_inc;
  logic                  match;
  logic                  walk_more;
  logic [IDX_W-1:0]      rd_addr;

  logic                  heads_we;
  logic [BKT_W-1:0]      heads_wa;
  logic [LINK_W-1:0]     heads_wd;
  logic                  keys_we;
  logic                  vals_we;
  logic [IDX_W-1:0]      vals_wa;
  logic                  links_we;
  logic [IDX_W-1:0]      links_wa;
  logic [LINK_W-1:0]     links_wd;

  chm_hash u_hash (
    .key       (key),
    .magnitude (mag_c),
    .hash_key  (kmag),
    .bucket    (bkt_c)
  );

  assign busy = (state != S_IDLE);

  // Entries never written keep their reset meaning through the valid bits.
  assign head_q    = head_v ? head_raw : NIL;
  assign link_eff  = link_v ? link_raw : LINK_W'(link_a) + LINK_W'(1);
  assign steps_inc = steps + LINK_W'(1);
  assign match     = (key_q == kmag);
  assign walk_more = !match && (link_eff < NIL) && (steps_inc < LINK_W'(ENTRIES));

  always_comb begin
    case (state)
      S_HEAD:  rd_addr = (head_q < NIL) ? head_q[IDX_W-1:0] : free_head[IDX_W-1:0];
      S_CMP:   rd_addr = walk_more ? link_eff[IDX_W-1:0] : free_head[IDX_W-1:0];
      default: rd_addr = free_head[IDX_W-1:0];
    endcase
  end

  always_comb begin
    heads_we = 1'b0;
    heads_wa = bucket;
    heads_wd = free_head;
    keys_we  = 1'b0;
    vals_we  = 1'b0;
    vals_wa  = free_head[IDX_W-1:0];
    links_we = 1'b0;
    links_wa = free_head[IDX_W-1:0];
    links_wd = chain_head;
    case (state)
      S_CMP: begin
        if (match && act == ACT_SET) begin
          vals_we = 1'b1;
          vals_wa = cur;
        end
      end
      S_ALLOC: begin
        heads_we = 1'b1;
        keys_we  = 1'b1;
        vals_we  = 1'b1;
        links_we = 1'b1;
      end
      S_REM1: begin
        if (prev < NIL) begin
          links_we = 1'b1;
          links_wa = prev[IDX_W-1:0];
          links_wd = hit_link;
        end else begin
          heads_we = 1'b1;
          heads_wd = hit_link;
        end
      end
      S_REM2: begin
        links_we = 1'b1;
        links_wa = cur;
        links_wd = free_head;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    head_raw <= heads[bkt_c];
    head_v   <= head_vld[bkt_c];
    key_q    <= keys[rd_addr];
    val_q    <= vals[rd_addr];
    link_raw <= links[rd_addr];
    link_v   <= link_vld[rd_addr];
    link_a   <= rd_addr;
    if (heads_we) begin
      heads[heads_wa] <= heads_wd;
    end
    if (keys_we) begin
      keys[free_head[IDX_W-1:0]] <= kmag;
    end
    if (vals_we) begin
      vals[vals_wa] <= val;
    end
    if (links_we) begin
      links[links_wa] <= links_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head_vld <= '0;
      link_vld <= '0;
    end else begin
      if (heads_we) begin
        head_vld[heads_wa] <= 1'b1;
      end
      if (links_we) begin
        link_vld[links_wa] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      done        <= 1'b0;
      free_head   <= '0;
      count       <= '0;
      entry_count <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            act   <= action;
            kmag  <= mag_c;
            val   <= value_in[VALUE_BITS-1:0];
            state <= S_HASH;
          end
        end
        S_HASH: begin
          bucket <= bkt_c;
          state  <= S_HEAD;
        end
        S_HEAD: begin
          chain_head <= head_q;
          prev       <= NIL;
          steps      <= '0;
          cur        <= head_q[IDX_W-1:0];
          if (head_q < NIL) begin
            state <= S_CMP;
          end else if (act == ACT_SET && free_head < NIL) begin
            state <= S_ALLOC;
          end else begin
            done        <= 1'b1;
            found       <= 1'b0;
            value_out   <= '0;
            status      <= (act == ACT_SET);
            entry_count <= 9'(count);
            state       <= S_IDLE;
          end
        end
        S_CMP: begin
          if (match) begin
            hit_link <= link_eff;
            if (act == ACT_REMOVE) begin
              state <= S_REM1;
            end else begin
              done        <= 1'b1;
              found       <= 1'b1;
              value_out   <= (act == ACT_SET) ? '0 : 64'(val_q);
              status      <= 1'b0;
              entry_count <= 9'(count);
              state       <= S_IDLE;
            end
          end else if (walk_more) begin
            prev  <= LINK_W'(cur);
            cur   <= link_eff[IDX_W-1:0];
            steps <= steps_inc;
          end else if (act == ACT_SET && free_head < NIL) begin
            state <= S_ALLOC;
          end else begin
            done        <= 1'b1;
            found       <= 1'b0;
            value_out   <= '0;
            status      <= (act == ACT_SET);
            entry_count <= 9'(count);
            state       <= S_IDLE;
          end
        end
        S_ALLOC: begin
          // The link read issued at the decision cycle gives the next free entry.
          free_head   <= link_eff;
          count       <= count + LINK_W'(1);
          done        <= 1'b1;
          found       <= 1'b0;
          value_out   <= '0;
          status      <= 1'b0;
          entry_count <= 9'(count + LINK_W'(1));
          state       <= S_IDLE;
        end
        S_REM1: begin
          state <= S_REM2;
        end
        S_REM2: begin
          free_head   <= LINK_W'(cur);
          count       <= (count != '0) ? count - LINK_W'(1) : count;
          done        <= 1'b1;
          found       <= 1'b1;
          value_out   <= '0;
          status      <= 1'b0;
          entry_count <= 9'((count != '0) ? count - LINK_W'(1) : count);
          state       <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result shown while the sequencer is still working");

  a_full_not_found: assert property (@(posedge clk) disable iff (rst)
    (done && status) |-> !found)
    else $error("pool full reported for a key that was present");

  a_value_needs_hit: assert property (@(posedge clk) disable iff (rst)
    (done && value_out != 64'd0) |-> found)
    else $error("value returned without a hit");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= LINK_W'(ENTRIES))
    else $error("entry count exceeds pool size");

endmodule
